FILE: rtl/smmf_pkg.sv
// ----------------------------------------------------------------------------
// smmf_pkg
// Shared constants and types for the histogram mode and maximum finder.
// ----------------------------------------------------------------------------
`default_nettype none

package smmf_pkg;

	localparam int SET_SIZE_MAX = 1024;
	localparam int VALUE_BITS   = 8;
	localparam int NUM_BINS     = 1 << VALUE_BITS;

	// a count reaches SET_SIZE_MAX, a first index stays below it
	localparam int COUNT_W = $clog2(SET_SIZE_MAX + 1);
	localparam int FIRST_W = $clog2(SET_SIZE_MAX);
	localparam int IDX_W   = $clog2(SET_SIZE_MAX + 1);
	localparam int BIN_W   = COUNT_W + FIRST_W;

	// port widths of the payload
	localparam int SAMPLE_W = 8;
	localparam int LARGE_W  = 8;
	localparam int MODE_W   = 8;
	localparam int MCOUNT_W = 11;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [FIRST_W-1:0]    first_t;

	// updated bin of the item in stage 1
	typedef struct packed {
		logic   vld;
		logic   last;
		logic   tallied;
		logic   first_item;
		value_t value;
		count_t cnt;
		first_t first;
	} upd_t;

endpackage

`default_nettype wire

FILE: rtl/smmf_hist_ram.sv
// ----------------------------------------------------------------------------
// smmf_hist_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smmf_hist_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 21
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/smmf_tally.sv
// ----------------------------------------------------------------------------
// smmf_tally
// Histogram read-modify-write: reads the bin at accept, updates it in stage 1
// and writes it back, forwarding the previous write on an address match.
// ----------------------------------------------------------------------------
`default_nettype none

module smmf_tally (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire smmf_pkg::value_t             value,
	input  wire logic                         last,
	input  wire logic                         advance,
	output smmf_pkg::upd_t                    upd
);
	import smmf_pkg::*;

	logic                vld_s1;
	logic                last_s1;
	value_t              value_s1;
	logic                fwd_s1;
	logic [IDX_W-1:0]    idx_q;
	logic [NUM_BINS-1:0] bin_vld_q;
	count_t              fwd_cnt_q;
	first_t              fwd_first_q;
	logic [BIN_W-1:0]    rd_data;
	count_t              old_cnt;
	first_t              old_first;
	logic                hit;
	logic                tallied;
	logic                wr_en;
	count_t              new_cnt;
	first_t              new_first;

	smmf_hist_ram #(
		.ADDR_W(VALUE_BITS),
		.DATA_W(BIN_W)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(value_s1),
		.wdata({new_cnt, new_first}),
		.re   (accept),
		.raddr(value),
		.rdata(rd_data)
	);

	assign tallied = idx_q < IDX_W'(SET_SIZE_MAX);
	assign hit     = bin_vld_q[value_s1];
	// the read raced the previous write to the same bin: take the written data
	assign old_cnt   = fwd_s1 ? fwd_cnt_q : rd_data[BIN_W-1:FIRST_W];
	assign old_first = fwd_s1 ? fwd_first_q : rd_data[FIRST_W-1:0];
	assign new_cnt   = hit ? count_t'(old_cnt + 1'b1) : count_t'(1);
	assign new_first = hit ? old_first : idx_q[FIRST_W-1:0];
	assign wr_en     = vld_s1 && advance && tallied;

	always_comb begin
		upd.vld        = vld_s1;
		upd.last       = last_s1;
		upd.tallied    = tallied;
		upd.first_item = idx_q == '0;
		upd.value      = value_s1;
		upd.cnt        = new_cnt;
		upd.first      = new_first;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			idx_q     <= '0;
			bin_vld_q <= '0;
			fwd_s1    <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				fwd_s1 <= wr_en && (value_s1 == value);
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (vld_s1 && advance) begin
				if (last_s1) begin
					idx_q     <= '0;
					bin_vld_q <= '0;
				end else begin
					if (tallied) begin
						idx_q <= idx_q + 1'b1;
					end
					if (wr_en) begin
						bin_vld_q[value_s1] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= value;
			last_s1  <= last;
		end
		if (wr_en) begin
			fwd_cnt_q   <= new_cnt;
			fwd_first_q <= new_first;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/smmf_track.sv
// ----------------------------------------------------------------------------
// smmf_track
// Running maximum, best bin and overflow flag of the set, plus the result
// register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module smmf_track (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire smmf_pkg::upd_t               upd,
	output logic                              advance,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [smmf_pkg::LARGE_W-1:0]      largest_value,
	output logic [smmf_pkg::MODE_W-1:0]       mode_value,
	output logic [smmf_pkg::MCOUNT_W-1:0]     mode_count,
	output logic                              set_overflow
);
	import smmf_pkg::*;

	value_t best_value_q;
	count_t best_cnt_q;
	first_t best_first_q;
	value_t max_q;
	logic   ovf_q;
	logic   better;
	value_t nxt_value;
	count_t nxt_cnt;
	first_t nxt_first;
	value_t nxt_max;
	logic   nxt_ovf;

	// hold a finished set while the result register is still occupied
	assign advance = upd.vld && (!upd.last || !out_valid || out_ready);

	assign better = (upd.cnt > best_cnt_q)
		|| ((upd.cnt == best_cnt_q) && (upd.first < best_first_q));

	always_comb begin
		nxt_value = best_value_q;
		nxt_cnt   = best_cnt_q;
		nxt_first = best_first_q;
		nxt_max   = max_q;
		nxt_ovf   = ovf_q || !upd.tallied;
		if (upd.tallied) begin
			if (better) begin
				nxt_value = upd.value;
				nxt_cnt   = upd.cnt;
				nxt_first = upd.first;
			end
			if (upd.first_item || (upd.value > max_q)) begin
				nxt_max = upd.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_value_q <= '0;
			best_cnt_q   <= '0;
			best_first_q <= '0;
			max_q        <= '0;
			ovf_q        <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (advance) begin
				if (upd.last) begin
					best_value_q <= '0;
					best_cnt_q   <= '0;
					best_first_q <= '0;
					max_q        <= '0;
					ovf_q        <= 1'b0;
					out_valid    <= 1'b1;
				end else begin
					best_value_q <= nxt_value;
					best_cnt_q   <= nxt_cnt;
					best_first_q <= nxt_first;
					max_q        <= nxt_max;
					ovf_q        <= nxt_ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && upd.last) begin
			largest_value <= LARGE_W'(nxt_max);
			mode_value    <= MODE_W'(nxt_value);
			mode_count    <= MCOUNT_W'(nxt_cnt);
			set_overflow  <= nxt_ovf;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/stream_max_and_mode_finder.sv
// ----------------------------------------------------------------------------
// stream_max_and_mode_finder
// Histogram of a streamed set with maximum and mode reported per set.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one sample per transfer, last_item marks
// the end of a set. Output channel (out_valid/out_ready): one result per set
// with the largest value, the most frequent value (earliest first occurrence
// on ties), its count and an overflow flag for sets longer than SET_SIZE_MAX.
// Throughput is one sample per cycle, save for the set-end stall below: the
// bin read is issued at the input transfer, the bin is updated and written
// back in the update stage, and a same-bin collision between neighboring
// samples is forwarded from the previous write. The final sample passes the
// update stage and then loads the output register, raising out_valid; new
// samples keep flowing while the result waits there, and only a second set
// end stalls (in_ready low) until the receiver takes the pending result.
// Reset clears the valid bits of all bins and the set state; the bin memory
// itself needs no clearing pass and the block is ready right after reset.
// Bin valid bits clear all at once at each set end.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_max_and_mode_finder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [smmf_pkg::SAMPLE_W-1:0] sample_value,
	input  wire logic                          last_item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [smmf_pkg::LARGE_W-1:0]       largest_value,
	output logic [smmf_pkg::MODE_W-1:0]        mode_value,
	output logic [smmf_pkg::MCOUNT_W-1:0]      mode_count,
	output logic                               set_overflow
);
	import smmf_pkg::*;

	upd_t   upd;
	logic   advance;
	logic   accept;
	value_t value_in;

	assign in_ready = !upd.vld || advance;
	assign accept   = in_valid && in_ready;
	// drop the sample bits above the histogram range
	assign value_in = sample_value[VALUE_BITS-1:0];

	smmf_tally u_tally (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.value  (value_in),
		.last   (last_item),
		.advance(advance),
		.upd    (upd)
	);

	smmf_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd          (upd),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.largest_value(largest_value),
		.mode_value   (mode_value),
		.mode_count   (mode_count),
		.set_overflow (set_overflow)
	);

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mode_count != '0)
			&& (mode_count <= MCOUNT_W'(SET_SIZE_MAX)))
		else $error("mode count out of range");

	a_set_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && upd.last) |=> out_valid)
		else $error("set end did not load a result");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!upd.vld |-> in_ready)
		else $error("input stalled with an empty update stage");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(upd.vld && upd.tallied) |-> (upd.cnt != '0)
			&& (upd.cnt <= COUNT_W'(SET_SIZE_MAX)))
		else $error("bin count update out of range");
`endif

endmodule

`default_nettype wire
